// ----- src/tsla_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsla_pkg
// Shared types and constants for the triangle strip/list assembler.
// ----------------------------------------------------------------------------
package tsla_pkg;

    localparam int INDEX_WIDTH_DEF = 32;
    localparam int CORNER_WIDTH    = 32;
    localparam int FILL_WIDTH      = 2;

    // number of held indices at which the next index closes a triangle
    localparam logic [FILL_WIDTH-1:0] WINDOW_FULL = 2'd2;

    localparam logic TOPO_LIST  = 1'b0;
    localparam logic TOPO_STRIP = 1'b1;

    localparam logic [CORNER_WIDTH-1:0] RESTART_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                    emit;
        logic [CORNER_WIDTH-1:0] corner_a;
        logic [CORNER_WIDTH-1:0] corner_b;
        logic [CORNER_WIDTH-1:0] corner_c;
    } tri_t;

endpackage
`default_nettype wire

// ----- src/tsla_window.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsla_window
// Index window (two previous indices, fill count, winding parity) and the
// combinational triangle assembly for the item held in the input register.
// ----------------------------------------------------------------------------
module tsla_window #(
    parameter int INDEX_WIDTH = tsla_pkg::INDEX_WIDTH_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire [tsla_pkg::CORNER_WIDTH-1:0] restart_value,
    input  wire                              advance,
    input  wire [tsla_pkg::CORNER_WIDTH-1:0] vertex_index,
    input  wire [tsla_pkg::CORNER_WIDTH-1:0] base_offset,
    input  wire                              topology,
    input  wire                              part_end,
    output tsla_pkg::tri_t                   tri_out
);
    import tsla_pkg::*;

    logic [INDEX_WIDTH-1:0] older_reg, older_next;
    logic [INDEX_WIDTH-1:0] newer_reg, newer_next;
    logic [FILL_WIDTH-1:0]  fill_reg, fill_next;
    logic                   odd_reg, odd_next;

    logic [INDEX_WIDTH-1:0] idx;
    logic                   is_strip;
    logic                   is_restart;
    logic                   full;
    logic [INDEX_WIDTH-1:0] first_idx;
    logic [INDEX_WIDTH-1:0] second_idx;

    assign idx        = vertex_index[INDEX_WIDTH-1:0];
    assign is_strip   = (topology == TOPO_STRIP);
    assign is_restart = (idx == restart_value[INDEX_WIDTH-1:0]);
    assign full       = (fill_reg == WINDOW_FULL);

    // odd strip triangles swap the two older corners to keep winding
    assign first_idx  = (is_strip && odd_reg) ? newer_reg : older_reg;
    assign second_idx = (is_strip && odd_reg) ? older_reg : newer_reg;

    always_comb begin
        tri_out.emit     = full && !(is_strip && is_restart);
        tri_out.corner_a = CORNER_WIDTH'(first_idx) + base_offset;
        tri_out.corner_b = CORNER_WIDTH'(second_idx) + base_offset;
        tri_out.corner_c = CORNER_WIDTH'(idx) + base_offset;
    end

    always_comb begin
        older_next = older_reg;
        newer_next = newer_reg;
        fill_next  = fill_reg;
        odd_next   = odd_reg;
        if (advance) begin
            if (part_end) begin
                older_next = '0;
                newer_next = '0;
                fill_next  = '0;
                odd_next   = 1'b0;
            end else if (is_strip && is_restart) begin
                fill_next = '0;
                odd_next  = 1'b0;
            end else if (!full) begin
                older_next = newer_reg;
                newer_next = idx;
                fill_next  = fill_reg + FILL_WIDTH'(1);
            end else begin
                older_next = newer_reg;
                newer_next = idx;
                if (is_strip) begin
                    odd_next = !odd_reg;
                end else begin
                    fill_next = '0;
                    odd_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_reg <= '0;
            newer_reg <= '0;
            fill_reg  <= '0;
            odd_reg   <= 1'b0;
        end else begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            fill_reg  <= fill_next;
            odd_reg   <= odd_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/triangle_strip_list_assembler_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_strip_list_assembler_top
// Primitive assembler: vertex indices in, triangles of offset indices out.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ stream carries one vertex index per transaction, with the mesh
//   base offset in tdata, the topology (0 list, 1 strip) in tuser and the
//   end-of-part mark in tlast. The m_ stream carries one triangle per
//   transaction: three corner indices with the base offset added mod 2^32.
//   Not every index yields a triangle; list leftovers at a part end and strip
//   restart indices yield nothing.
//   The cfg channel writes the strip restart index; write it only while no
//   transaction is in flight. cfg_ready is high whenever reset is released.
// Pipeline and throughput:
//   The transaction that closes a triangle passes from the input register
//   through the window into the output register, which raises m_tvalid.
//   One index is taken every cycle while the receiver does not stall; the
//   rate is set by the combinational window update between the two registers.
// Reset and stall:
//   Reset empties both registers, clears the index window and sets the
//   restart index to all ones. While the receiver stalls, the output holds
//   and one more index waits in the input register before s_tready drops.
// ----------------------------------------------------------------------------
module triangle_strip_list_assembler_top #(
    parameter int INDEX_WIDTH = tsla_pkg::INDEX_WIDTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [31:0] cfg_data,
    // index stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // [31:0] vertex_index, [63:32] base_offset
    input  wire  [0:0]  s_tuser,   // [0] topology
    input  wire         s_tlast,   // part_end
    // triangle stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [95:0] m_tdata    // [31:0] corner_a, [63:32] corner_b,
                                   // [95:64] corner_c
);
    import tsla_pkg::*;

    logic [CORNER_WIDTH-1:0] restart_reg;

    // input register
    logic                    in_valid_reg;
    logic [CORNER_WIDTH-1:0] in_vidx_reg;
    logic [CORNER_WIDTH-1:0] in_off_reg;
    logic                    in_topo_reg;
    logic                    in_last_reg;

    // output register
    logic                    out_valid_reg;
    logic [CORNER_WIDTH-1:0] out_a_reg;
    logic [CORNER_WIDTH-1:0] out_b_reg;
    logic [CORNER_WIDTH-1:0] out_c_reg;

    logic  advance;
    logic  s_accept;
    tri_t  tri_w;

    // move the held index on when the output register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = aresetn && (!in_valid_reg || advance);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            restart_reg <= RESTART_RESET;
        end else if (cfg_valid && cfg_ready) begin
            restart_reg <= cfg_data;
        end
    end

    // load a new transaction into the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_vidx_reg <= s_tdata[31:0];
            in_off_reg  <= s_tdata[63:32];
            in_topo_reg <= s_tuser[0];
            in_last_reg <= s_tlast;
        end
    end

    tsla_window #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .restart_value (restart_reg),
        .advance       (advance),
        .vertex_index  (in_vidx_reg),
        .base_offset   (in_off_reg),
        .topology      (in_topo_reg),
        .part_end      (in_last_reg),
        .tri_out       (tri_w)
    );

    // capture a finished triangle; drop items that close none
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= tri_w.emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && tri_w.emit) begin
            out_a_reg <= tri_w.corner_a;
            out_b_reg <= tri_w.corner_b;
            out_c_reg <= tri_w.corner_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_c_reg, out_b_reg, out_a_reg};

endmodule
`default_nettype wire

// ----- src/tsla_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsla_checker
// Port-level checks for the triangle assembler, bound to the top level.
// ----------------------------------------------------------------------------
module tsla_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [95:0] m_tdata
);

    // a stalled triangle holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled triangle changed or vanished");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a new triangle comes from an earlier accepted index transaction
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("triangle without a source transaction");

    // a ready receiver never backs up the index stream
    a_no_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

endmodule

bind triangle_strip_list_assembler_top tsla_checker u_tsla_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- bench/triangle_strip_list_assembler_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_strip_list_assembler_top_tb
// Self-checking bench for the primitive assembler. A queue of vertex index
// transactions feeds a clocked driver. A clocked monitor runs every accepted
// index through a local copy of the assembly window and checks each triangle
// leaving the block against the oldest expected one. Both sides idle at
// random. The restart index is rewritten between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module triangle_strip_list_assembler_top_tb;

    import tsla_pkg::*;

    localparam int          IDX_W          = INDEX_WIDTH_DEF;
    localparam logic [31:0] IDX_MASK       = 32'hFFFF_FFFF >> (32 - IDX_W);
    localparam int          SETTLE_CYCLES  = 8;      // pipeline is two deep
    localparam int          LONG_HOLD      = 300;    // receiver hold-off, cycles
    localparam int          PHASE_ITEMS    = 240;
    localparam int          RANDOM_PHASES  = 6;
    localparam longint      TIMEOUT_NS     = 2_000_000;

    // one vertex index transaction on the s_ stream
    typedef struct {
        logic [31:0] vertex_index;
        logic [31:0] base_offset;
        logic        topology;
        logic        part_end;
    } vtx_item_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic [63:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;

    wire         cfg_ready;
    wire         s_tready;
    wire         m_tvalid;
    wire  [95:0] m_tdata;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    triangle_strip_list_assembler_top #(
        .INDEX_WIDTH(IDX_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [31:0] vertex_index, [63:32] base_offset
        .s_tuser  (s_tuser),    // [0] topology
        .s_tlast  (s_tlast),    // part_end
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // [31:0] corner_a, [63:32] corner_b, [95:64] corner_c
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    vtx_item_t index_queue[$];      // indices waiting to be driven
    tri_t      tri_expect[$];       // triangles predicted, not yet seen
    int        error_count = 0;

    // local copy of the assembly window and the restart register
    logic [31:0]           restart_idx = RESTART_RESET;
    logic [31:0]           win_older   = '0;
    logic [31:0]           win_newer   = '0;
    logic [FILL_WIDTH-1:0] win_fill    = '0;
    logic                  win_odd     = 1'b0;

    // idling controls, set per phase by the stimulus process
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;

    // handshake seen at the last rising edge, used by the driver
    bit tx_taken  = 1'b0;
    int tx_gap    = 0;
    int rx_gap    = 0;
    int hold_left = 0;

    // Gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 10);
        else             return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: advance the window by one index and return the triangle it
    // closes, if any (emit set).
    // ------------------------------------------------------------------------
    function automatic tri_t assemble_triangle(input vtx_item_t it);
        tri_t        t;
        logic [31:0] idx;
        logic [31:0] first;
        logic [31:0] second;
        t   = '0;
        idx = it.vertex_index & IDX_MASK;
        if (it.topology == TOPO_STRIP) begin
            if (idx == (restart_idx & IDX_MASK)) begin
                // restart: drop the window, keep the newest indices as they are
                win_fill = '0;
                win_odd  = 1'b0;
            end else if (win_fill < WINDOW_FULL) begin
                win_older = win_newer;
                win_newer = idx;
                win_fill  = win_fill + FILL_WIDTH'(1);
            end else begin
                // odd strip triangles swap their first two corners
                first      = win_odd ? win_newer : win_older;
                second     = win_odd ? win_older : win_newer;
                t.emit     = 1'b1;
                t.corner_a = first + it.base_offset;
                t.corner_b = second + it.base_offset;
                t.corner_c = idx + it.base_offset;
                win_older  = win_newer;
                win_newer  = idx;
                win_odd    = ~win_odd;
            end
        end else begin
            // list mode: the restart value is an ordinary index here
            if (win_fill < WINDOW_FULL) begin
                win_older = win_newer;
                win_newer = idx;
                win_fill  = win_fill + FILL_WIDTH'(1);
            end else begin
                t.emit     = 1'b1;
                t.corner_a = win_older + it.base_offset;
                t.corner_b = win_newer + it.base_offset;
                t.corner_c = idx + it.base_offset;
                win_older  = win_newer;
                win_newer  = idx;
                win_fill   = '0;
                win_odd    = 1'b0;
            end
        end
        if (it.part_end) begin
            win_older = '0;
            win_newer = '0;
            win_fill  = '0;
            win_odd   = 1'b0;
        end
        return t;
    endfunction

    function automatic void check_corner(input string name, input logic [31:0] expected,
                                         input logic [31:0] actual);
        if (actual !== expected) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $time, name, expected, actual);
            error_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample both streams at the rising edge. Predict on every
    // accepted index, check every accepted triangle against the oldest one.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        vtx_item_t it;
        tri_t      t;
        tx_taken = aresetn && s_tvalid && s_tready;
        if (tx_taken) begin
            it.vertex_index = s_tdata[31:0];
            it.base_offset  = s_tdata[63:32];
            it.topology     = s_tuser[0];
            it.part_end     = s_tlast;
            t = assemble_triangle(it);
            if (t.emit)
                tri_expect.insert(tri_expect.size(), t);
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (tri_expect.size() == 0) begin
                $display("%0t ns: unexpected triangle, expected none, actual %h",
                         $time, m_tdata);
                error_count++;
            end else begin
                t = tri_expect.pop_front();
                check_corner("corner_a", t.corner_a, m_tdata[31:0]);
                check_corner("corner_b", t.corner_b, m_tdata[63:32]);
                check_corner("corner_c", t.corner_c, m_tdata[95:64]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: at the falling edge, hold the current transaction until it is
    // taken, then idle for a random gap or advance to the next queued index.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        vtx_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || tx_taken) begin
            if (tx_gap > 0) begin
                s_tvalid <= 1'b0;
                tx_gap--;
            end else if (index_queue.size() != 0) begin
                it = index_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {it.base_offset, it.vertex_index};
                s_tuser  <= it.topology;
                s_tlast  <= it.part_end;
                tx_gap   = tx_idle_on ? gap_len() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request so that the
    // block fills up and drops s_tready.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap--;
        end else begin
            m_tready <= 1'b1;
            rx_gap = rx_idle_on ? gap_len() : 0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_index(input logic [31:0] vidx, input logic [31:0] off,
                               input logic topo, input logic last);
        vtx_item_t it;
        it.vertex_index = vidx;
        it.base_offset  = off;
        it.topology     = topo;
        it.part_end     = last;
        index_queue.insert(index_queue.size(), it);
    endtask

    // Wait until every index is taken and every triangle has come out, then
    // let the pipeline settle in case the last indices produced nothing.
    task automatic wait_drained();
        do @(posedge aclk);
        while (index_queue.size() != 0 || s_tvalid || tri_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_restart(input logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        restart_idx = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_offset();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)      return 32'h0000_0000;
        else if (r == 1) return 32'hFFFF_FFFF;
        else if (r == 2) return 32'hFFFF_FFF0 | $urandom_range(0, 15);
        else             return $urandom;
    endfunction

    function automatic logic [31:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 7)       return restart_idx;
        else if (r < 12) return 32'h0000_0000;
        else if (r < 17) return 32'hFFFF_FFFF;
        else if (r < 30) return $urandom_range(0, 15);
        else             return $urandom;
    endfunction

    // One part: mostly well-formed runs of one topology, some mixed, some
    // short ones, and now and then a part that runs on without an end mark.
    task automatic queue_part(output int len);
        int          shape;
        bit          mixed;
        logic        topo;
        logic [31:0] off;
        shape = $urandom_range(0, 99);
        if (shape < 10)      len = $urandom_range(1, 2);
        else if (shape < 90) len = $urandom_range(3, 12);
        else                 len = $urandom_range(13, 40);
        topo  = 1'($urandom_range(0, 1));
        mixed = ($urandom_range(0, 9) == 0);
        off   = pick_offset();
        for (int i = 0; i < len; i++) begin
            if (mixed)
                topo = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 19) == 0)
                off = pick_offset();
            queue_index(pick_index(), off, topo,
                        (i == len - 1) && ($urandom_range(0, 9) != 0));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] restart_plan[RANDOM_PHASES];
        int          phase_items;
        int          len;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, restart index still at its reset value.
        // list triangle with extreme indices and an offset that wraps
        queue_index(32'h0000_0000, 32'hFFFF_FFFF, TOPO_LIST, 1'b0);
        queue_index(32'hFFFF_FFFF, 32'hFFFF_FFFF, TOPO_LIST, 1'b0);
        queue_index(32'h0000_0001, 32'hFFFF_FFFF, TOPO_LIST, 1'b1);
        // unfinished list triangles at a part end: dropped
        queue_index(32'h0000_0010, 32'h0000_0000, TOPO_LIST, 1'b0);
        queue_index(32'h0000_0011, 32'h0000_0000, TOPO_LIST, 1'b1);
        queue_index(32'h0000_0012, 32'h0000_0000, TOPO_LIST, 1'b1);
        // strip with an offset change inside the part, odd triangles swap
        queue_index(32'h0000_0020, 32'h0000_1000, TOPO_STRIP, 1'b0);
        queue_index(32'h0000_0021, 32'h0000_1000, TOPO_STRIP, 1'b0);
        queue_index(32'h0000_0022, 32'h8000_0000, TOPO_STRIP, 1'b0);
        queue_index(32'h0000_0023, 32'h0000_0000, TOPO_STRIP, 1'b1);
        // short strip: nothing
        queue_index(32'h0000_0030, 32'h0000_0005, TOPO_STRIP, 1'b0);
        queue_index(32'h0000_0031, 32'h0000_0005, TOPO_STRIP, 1'b1);
        // strip restart in the middle of a part
        queue_index(32'h0000_0040, 32'h0000_0000, TOPO_STRIP, 1'b0);
        queue_index(32'h0000_0041, 32'h0000_0000, TOPO_STRIP, 1'b0);
        queue_index(32'h0000_0042, 32'h0000_0000, TOPO_STRIP, 1'b0);
        queue_index(32'hFFFF_FFFF, 32'h0000_0000, TOPO_STRIP, 1'b0);
        queue_index(32'h0000_0043, 32'h0000_0000, TOPO_STRIP, 1'b0);
        queue_index(32'h0000_0044, 32'h0000_0000, TOPO_STRIP, 1'b0);
        queue_index(32'h0000_0045, 32'h0000_0000, TOPO_STRIP, 1'b1);
        // topology change inside a part: a list triangle clears the parity
        queue_index(32'h0000_0050, 32'h0000_0100, TOPO_STRIP, 1'b0);
        queue_index(32'h0000_0051, 32'h0000_0100, TOPO_STRIP, 1'b0);
        queue_index(32'h0000_0052, 32'h0000_0100, TOPO_STRIP, 1'b0);
        queue_index(32'h0000_0053, 32'h0000_0100, TOPO_LIST,  1'b0);
        queue_index(32'h0000_0054, 32'h0000_0100, TOPO_STRIP, 1'b0);
        queue_index(32'h0000_0055, 32'h0000_0100, TOPO_STRIP, 1'b1);
        wait_drained();

        // Random phases, each with its own restart index, extremes included.
        restart_plan[0] = 32'h0000_0000;
        restart_plan[1] = 32'hFFFF_FFFF;
        restart_plan[2] = $urandom;
        restart_plan[3] = 32'h0000_0007;
        restart_plan[4] = 32'h8000_0000;
        restart_plan[5] = $urandom;

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_restart(restart_plan[p]);
            // phase 1: sender runs flat out while the receiver holds off;
            // phase 2: no idling on either side
            tx_idle_on = (p != 1) && (p != 2);
            rx_idle_on = (p != 2);
            if (p == 1)
                hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                queue_part(len);
                phase_items += len;
            end
            // sender pauses here until every triangle has come out
            wait_drained();
        end

        if (error_count == 0 && tri_expect.size() == 0) begin
            $display("** triangle_strip_list_assembler_top: PASSED **");
        end else begin
            $display("** triangle_strip_list_assembler_top: FAILED **");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #(TIMEOUT_NS);
        $display("** triangle_strip_list_assembler_top: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tsla_pkg.sv
src/tsla_window.sv
src/triangle_strip_list_assembler_top.sv
src/tsla_checker.sv
bench/triangle_strip_list_assembler_top_tb.sv
